### hdl/divider_timer_serial_irq_macros.svh
// Assertion macros used by the timer block RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DIVIDER_TIMER_SERIAL_IRQ_MACROS_SVH
`define DIVIDER_TIMER_SERIAL_IRQ_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define DTSI_ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dtsi assertion failed");
// Concurrent assertion on the house clock and reset names.
`define DTSI_ASSERT(label, prop) \
    `DTSI_ASSERT_AT(label, i_clk, i_rst_n, prop)
`else
`define DTSI_ASSERT_AT(label, clk, rst_n, prop)
`define DTSI_ASSERT(label, prop)
`endif

`endif

### hdl/dtsi_pkg.sv
// Package of the timer block: command and register codes, masks, item types.
// Depends on nothing; used by dtsi_core and the top level of the block.
package dtsi_pkg;

    localparam logic [15:0] DIVIDER_STEP = 16'd4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [3:0] REG_SB   = 4'd1;
    localparam logic [3:0] REG_SC   = 4'd2;
    localparam logic [3:0] REG_DIV  = 4'd4;
    localparam logic [3:0] REG_TIMA = 4'd5;
    localparam logic [3:0] REG_TMA  = 4'd6;
    localparam logic [3:0] REG_TAC  = 4'd7;
    localparam logic [3:0] REG_IF   = 4'd15;

    // Divider bit positions for the timer taps and the serial clock.
    localparam int TAP_BIT_0  = 9;
    localparam int TAP_BIT_1  = 3;
    localparam int TAP_BIT_2  = 5;
    localparam int TAP_BIT_3  = 7;
    localparam int SERIAL_BIT = 8;
    localparam int TAC_ENABLE_BIT = 2;

    localparam logic [7:0] SC_START_MASK = 8'h81;
    localparam logic [3:0] SERIAL_COUNT  = 4'd8;
    localparam logic [7:0] IRQ_TIMER     = 8'h04;
    localparam logic [7:0] IRQ_SERIAL    = 8'h08;
    localparam logic [7:0] SB_READ_VALUE = 8'hFF;
    localparam logic [7:0] TIMA_MAX      = 8'hFF;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] reg_index;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] irq_flags;
    } t_result;

endpackage

### hdl/dtsi_channels.sv
// Valid/ready channel interfaces for the timer block's input and result items.
// Depends on nothing.
interface dtsi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, cmd, reg_index, write_data, input ready);
    modport sink   (input valid, cmd, reg_index, write_data, output ready);
endinterface

interface dtsi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] irq_flags;

    modport source (output valid, read_data, irq_flags, input ready);
    modport sink   (input valid, read_data, irq_flags, output ready);
endinterface

### hdl/dtsi_core.sv
// Timer, divider and serial-count state with the per-item update logic.
// Depends on dtsi_pkg and divider_timer_serial_irq_macros.svh.
`include "divider_timer_serial_irq_macros.svh"

module dtsi_core
    import dtsi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_result
);

    logic [15:0] r_div,  n_div;
    logic [7:0]  r_tima, n_tima;
    logic [7:0]  r_tma,  n_tma;
    logic [7:0]  r_tac,  n_tac;
    logic [7:0]  r_sb,   n_sb;
    logic [7:0]  r_sc,   n_sc;
    logic [7:0]  r_flags, n_flags;
    logic        r_prev_tim, n_prev_tim;
    logic [3:0]  r_ser_left, n_ser_left;
    logic        r_prev_ser, n_prev_ser;
    logic [15:0] div_inc;
    logic        ser_bit;
    logic        tap_bit;
    logic        tim_bit;
    logic [7:0]  rd;
    logic        tick_en;
    logic        nop_en;
    logic        div_clr_en;

    assign div_inc = r_div + DIVIDER_STEP;
    assign ser_bit = div_inc[SERIAL_BIT];

    always_comb begin
        unique case (r_tac[1:0])
            2'd0: tap_bit = div_inc[TAP_BIT_0];
            2'd1: tap_bit = div_inc[TAP_BIT_1];
            2'd2: tap_bit = div_inc[TAP_BIT_2];
            2'd3: tap_bit = div_inc[TAP_BIT_3];
        endcase
    end

    assign tim_bit = tap_bit & r_tac[TAC_ENABLE_BIT];

    always_comb begin
        n_div      = r_div;
        n_tima     = r_tima;
        n_tma      = r_tma;
        n_tac      = r_tac;
        n_sb       = r_sb;
        n_sc       = r_sc;
        n_flags    = r_flags;
        n_prev_tim = r_prev_tim;
        n_ser_left = r_ser_left;
        n_prev_ser = r_prev_ser;
        rd         = 8'h00;
        unique case (i_item.cmd)
            CMD_TICK: begin
                n_div = div_inc;
                // The serial count runs on falling edges of the serial clock bit.
                if (r_prev_ser && !ser_bit && (r_ser_left != 4'd0)) begin
                    n_ser_left = r_ser_left - 4'd1;
                    if (r_ser_left == 4'd1) begin
                        n_flags = n_flags | IRQ_SERIAL;
                    end
                end
                n_prev_ser = ser_bit;
                if (r_prev_tim && !tim_bit) begin
                    if (r_tima == TIMA_MAX) begin
                        n_tima  = r_tma;
                        n_flags = n_flags | IRQ_TIMER;
                    end else begin
                        n_tima = r_tima + 8'd1;
                    end
                end
                n_prev_tim = tim_bit;
            end
            CMD_READ: begin
                unique case (i_item.reg_index)
                    REG_SB:   rd = SB_READ_VALUE;
                    REG_SC:   rd = r_sc;
                    REG_DIV:  rd = r_div[15:8];
                    REG_TIMA: rd = r_tima;
                    REG_TMA:  rd = r_tma;
                    REG_TAC:  rd = r_tac;
                    REG_IF:   rd = r_flags;
                    default:  rd = 8'h00;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_item.reg_index)
                    REG_SB: n_sb = i_item.write_data;
                    REG_SC: begin
                        n_sc = i_item.write_data;
                        if ((i_item.write_data & SC_START_MASK) == SC_START_MASK) begin
                            n_ser_left = SERIAL_COUNT;
                        end
                    end
                    REG_DIV:  n_div   = 16'h0000;
                    REG_TIMA: n_tima  = i_item.write_data;
                    REG_TMA:  n_tma   = i_item.write_data;
                    REG_TAC:  n_tac   = i_item.write_data;
                    REG_IF:   n_flags = i_item.write_data;
                    default: begin
                    end
                endcase
            end
            CMD_NOP: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div      <= '0;
            r_tima     <= '0;
            r_tma      <= '0;
            r_tac      <= '0;
            r_sb       <= '0;
            r_sc       <= '0;
            r_flags    <= '0;
            r_prev_tim <= 1'b0;
            r_ser_left <= '0;
            r_prev_ser <= 1'b0;
        end else if (i_en) begin
            r_div      <= n_div;
            r_tima     <= n_tima;
            r_tma      <= n_tma;
            r_tac      <= n_tac;
            r_sb       <= n_sb;
            r_sc       <= n_sc;
            r_flags    <= n_flags;
            r_prev_tim <= n_prev_tim;
            r_ser_left <= n_ser_left;
            r_prev_ser <= n_prev_ser;
        end
    end

    assign o_result.read_data = rd;
    assign o_result.irq_flags = n_flags;

    // Accepted commands of interest for the checks below.
    assign tick_en    = i_en && (i_item.cmd == CMD_TICK);
    assign nop_en     = i_en && (i_item.cmd == CMD_NOP);
    assign div_clr_en = i_en && (i_item.cmd == CMD_WRITE) && (i_item.reg_index == REG_DIV);

    `DTSI_ASSERT(a_ser_left_bound, r_ser_left <= SERIAL_COUNT)
    `DTSI_ASSERT(a_div_clear, div_clr_en |=> (r_div == 16'h0000))
    `DTSI_ASSERT(a_tick_step, tick_en |=> (r_div == 16'($past(r_div) + DIVIDER_STEP)))
    `DTSI_ASSERT(a_nop_hold, nop_en |=> ($stable(r_div) && $stable(r_flags) && $stable(r_tima)))

endmodule

### hdl/divider_timer_serial_irq.sv
// Top level of the divider, timer and serial-interrupt block.
// Depends on dtsi_pkg, dtsi_channels.sv and dtsi_core.
//
// This block takes one command item per clock (tick, register read, register
// write or no operation) and returns exactly one result item for each, holding
// the byte read and the interrupt flags as they stand after that command.
// An item is accepted on the cycle its valid and ready are both high, and its
// result is presented from the output register on the following cycle. The
// sustained rate is one item per clock: the whole update of the divider, the
// timer counter and the serial count is a single pass of logic in front of the
// output register. Input ready stays high while the output register is empty or
// is being emptied in the same cycle, so a stalled consumer holds back only one
// item. No clearing pass follows reset; all but the payload go to zero at once.
module divider_timer_serial_irq
    import dtsi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtsi_in_if.sink    i_item,
    dtsi_out_if.source o_result
);

    logic    r_valid;
    t_result r_result;
    t_item   item;
    t_result core_result;
    logic    accept;

    // The output register can take a new result when it is empty or is being
    // taken in this cycle.
    assign i_item.ready = !r_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign item.cmd        = t_cmd'(i_item.cmd);
    assign item.reg_index  = i_item.reg_index;
    assign item.write_data = i_item.write_data;

    dtsi_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_item   (item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is loaded whenever an item is accepted.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= core_result;
        end
    end

    assign o_result.valid     = r_valid;
    assign o_result.read_data = r_result.read_data;
    assign o_result.irq_flags = r_result.irq_flags;

endmodule
